FILE: design/intra_pred_neighbor_line_store_defines.svh
// assertion macros shared by the neighbor line store rtl
// expects signals named clock and reset in the scope of use
`ifndef INTRA_PRED_NEIGHBOR_LINE_STORE_DEFINES_SVH
`define INTRA_PRED_NEIGHBOR_LINE_STORE_DEFINES_SVH

// same-cycle implication
`define IPNLS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IPNLS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/ipnls_pkg.sv
// shared constants, types and helpers of the neighbor line store
// no dependencies
`default_nettype none

package ipnls_pkg;

   localparam int MAX_MB_PER_ROW  = 64;
   localparam int COEFS_PER_BLOCK = 16;
   localparam int SLOT_COUNT      = MAX_MB_PER_ROW + 1;
   localparam int STORE_DEPTH     = SLOT_COUNT * COEFS_PER_BLOCK;

   localparam int SLOT_W    = $clog2(SLOT_COUNT);
   localparam int COEF_W    = $clog2(COEFS_PER_BLOCK);
   localparam int ADDR_W    = SLOT_W + COEF_W;
   localparam int MB_W      = 13;
   localparam int COEF_BITS = 16;
   localparam int PIX_W     = 4;
   localparam int ROW_CFG_W = 7;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 7;
   localparam int CNT_W     = $clog2(MB_W + 1);

   // generation tag kept next to every stored coefficient
   localparam int EPOCH_W = 8;
   localparam int ENTRY_W = EPOCH_W + COEF_BITS;
   localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

   localparam logic [ROW_CFG_W-1:0] MB_PER_ROW_RESET = ROW_CFG_W'(22);
   localparam logic [PIX_W-1:0]     PIXEL_BITS_RESET = PIX_W'(8);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MB_PER_ROW,
      CSR_PIXEL_BITS
   } csr_index_type;

   typedef struct packed {
      logic [EPOCH_W-1:0]   tag;
      logic [COEF_BITS-1:0] coef;
   } entry_type;

   typedef struct packed {
      logic              start;
      logic [MB_W-1:0]   dividend;
      logic [SLOT_W-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic              done;
      logic [SLOT_W-1:0] rem;
   } mod_stat_type;

   // dc predictor default, 1 << (bits + 2) cut to the coefficient width
   function automatic logic [COEF_BITS-1:0] default_dc(input logic [PIX_W-1:0] pb);
      logic [COEF_BITS+1:0] v;
      v = (COEF_BITS + 2)'(1) << (5'(pb) + 5'd2);
      return v[COEF_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: design/ipnls_ram.sv
// generic single write, dual read ram with registered read data
// no dependencies
`default_nettype none

module ipnls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr0,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr1,
   output logic      [WIDTH-1:0]         rd_data0,
   output logic      [WIDTH-1:0]         rd_data1
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data0_ff;
   logic [WIDTH-1:0] rd_data1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data0_ff <= mem_ff[rd_addr0];
         rd_data1_ff <= mem_ff[rd_addr1];
      end
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

`default_nettype wire

FILE: design/ipnls_mod_unit.sv
// bit-serial remainder of macroblock index by row width, one dividend bit a cycle
// depends on ipnls_pkg
`default_nettype none

module ipnls_mod_unit (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ipnls_pkg::mod_req_type  mod_req,
   output ipnls_pkg::mod_stat_type      mod_stat
);

   import ipnls_pkg::*;

   logic [MB_W-1:0]   shift_ff, shift_in;
   logic [SLOT_W-1:0] rem_ff, rem_in;
   logic [SLOT_W-1:0] divisor_ff, divisor_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [SLOT_W:0] trial;
   logic [SLOT_W:0] diff;
   logic            ge;

   always_comb begin
      trial = {rem_ff, shift_ff[MB_W-1]};
      diff  = trial - {1'b0, divisor_ff};
      ge    = trial >= {1'b0, divisor_ff};

      shift_in   = shift_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;

      if (mod_req.start) begin
         shift_in   = mod_req.dividend;
         rem_in     = '0;
         divisor_in = mod_req.divisor;
         cnt_in     = CNT_W'(MB_W);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         shift_in = shift_ff << 1;
         rem_in   = ge ? diff[SLOT_W-1:0] : trial[SLOT_W-1:0];
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff   <= shift_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      cnt_ff     <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign mod_stat.done = done_ff;
   assign mod_stat.rem  = rem_ff;

endmodule

`default_nettype wire

FILE: design/intra_pred_neighbor_line_store.sv
// neighbor line store for intra dc/ac prediction, top level
// depends on ipnls_pkg, ipnls_ram, ipnls_mod_unit and the assertion header
//
// Usage
//   req_* carries one coefficient transaction (macroblock index, resync flag,
//   coefficient index, left neighbor coefficient); rsp_* returns one result
//   with the echoed index and the a, b and c predictor coefficients.
//   csr_wr_en writes mb_per_row (index 0) or pixel_bits (index 1); write only
//   while the block is idle.
//   Flow: while the macroblock column is known, a transaction passes accept,
//   store read and result in that order, and the next one can be accepted as
//   its result is loaded into the output register; the ram read and the
//   read-then-write of the line store pace this. A new macroblock index or a csr
//   write adds the bit-serial column modulo before the store read. Picture start
//   or resync transactions go from accept straight to the result and do not read the store.
//   Reset: a clearing pass marks every store entry empty, with req_ready low.
//   The same pass runs after every 255th picture start or resync transaction,
//   when the entry generation tag wraps.
//   Stall: a result waits in the output register; one more transaction is
//   taken and worked up to the store read while rsp_ready is low.
`default_nettype none
`include "intra_pred_neighbor_line_store_defines.svh"

module intra_pred_neighbor_line_store (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic        [ipnls_pkg::MB_W-1:0]    req_mb_index,
   input  wire logic                                 req_resync,
   input  wire logic        [ipnls_pkg::COEF_W-1:0]  req_coef_index,
   input  wire logic signed [ipnls_pkg::COEF_BITS-1:0] req_left_coef,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic             [ipnls_pkg::COEF_W-1:0]  rsp_out_index,
   output logic signed      [ipnls_pkg::COEF_BITS-1:0] rsp_a_coef,
   output logic signed      [ipnls_pkg::COEF_BITS-1:0] rsp_b_coef,
   output logic signed      [ipnls_pkg::COEF_BITS-1:0] rsp_c_coef,
   input  wire logic                                 csr_wr_en,
   input  wire logic        [ipnls_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic        [ipnls_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   import ipnls_pkg::*;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_DIV,
      ST_RD,
      ST_EMIT
   } state_type;

   localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(STORE_DEPTH - 1);

   state_type state_ff, state_in;
   logic [ADDR_W-1:0]    sweep_ptr_ff, sweep_ptr_in;
   logic [EPOCH_W-1:0]   epoch_ff, epoch_in;
   logic [COEF_BITS-1:0] fill_dc_ff, fill_dc_in;
   logic [ROW_CFG_W-1:0] mb_per_row_ff, mb_per_row_in;
   logic [PIX_W-1:0]     pixel_bits_ff, pixel_bits_in;
   logic                 cache_ok_ff, cache_ok_in;
   logic [MB_W-1:0]      cache_mb_ff, cache_mb_in;
   logic [SLOT_W-1:0]    col_ff, col_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 it_fill_ff, it_fill_in;
   logic [MB_W-1:0]      it_mb_ff, it_mb_in;
   logic [COEF_W-1:0]    it_k_ff, it_k_in;
   logic [COEF_BITS-1:0] it_left_ff, it_left_in;
   logic [COEF_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [COEF_BITS-1:0] rsp_a_ff, rsp_a_in;
   logic [COEF_BITS-1:0] rsp_b_ff, rsp_b_in;
   logic [COEF_BITS-1:0] rsp_c_ff, rsp_c_in;

   logic [SLOT_W-1:0]    row_w;
   logic                 hit;
   logic                 req_fill;
   logic                 wrap;
   logic                 out_free;
   logic                 accept;
   logic                 emit_fire;
   logic [COEF_BITS-1:0] dflt;
   logic [COEF_BITS-1:0] fill_dflt;
   logic [COEF_BITS-1:0] b_val;
   logic [COEF_BITS-1:0] c_val;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   entry_type         ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr0;
   logic [ADDR_W-1:0] ram_rd_addr1;
   entry_type         ram_rd_data0;
   entry_type         ram_rd_data1;

   mod_req_type  mod_req;
   mod_stat_type mod_stat;

   ipnls_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock    (clock),
      .wr_en    (ram_wr_en),
      .wr_addr  (ram_wr_addr),
      .wr_data  (ram_wr_data),
      .rd_en    (ram_rd_en),
      .rd_addr0 (ram_rd_addr0),
      .rd_addr1 (ram_rd_addr1),
      .rd_data0 (ram_rd_data0),
      .rd_data1 (ram_rd_data1)
   );

   ipnls_mod_unit u_mod (
      .clock    (clock),
      .reset    (reset),
      .mod_req  (mod_req),
      .mod_stat (mod_stat)
   );

   // effective row width, zero acts as one, clamped to MAX_MB_PER_ROW
   always_comb begin
      if (mb_per_row_ff == '0) begin
         row_w = SLOT_W'(1);
      end else if (int'(mb_per_row_ff) > MAX_MB_PER_ROW) begin
         row_w = SLOT_W'(MAX_MB_PER_ROW);
      end else begin
         row_w = SLOT_W'(mb_per_row_ff);
      end
   end

   assign hit       = cache_ok_ff && (req_mb_index == cache_mb_ff);
   assign req_fill  = (req_mb_index == '0) || req_resync;
   assign wrap      = it_fill_ff && (epoch_ff == EPOCH_MAX);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) ||
                      ((state_ff == ST_EMIT) && out_free && !wrap);
   assign accept    = req_valid && req_ready;
   assign emit_fire = (state_ff == ST_EMIT) && out_free;

   // entries from an older generation read as the pattern of the last fill
   assign dflt      = (it_k_ff == '0) ? fill_dc_ff : '0;
   assign fill_dflt = (it_k_ff == '0) ? default_dc(pixel_bits_ff) : '0;
   assign b_val     = (ram_rd_data0.tag == epoch_ff) ? ram_rd_data0.coef : dflt;
   assign c_val     = (ram_rd_data1.tag == epoch_ff) ? ram_rd_data1.coef : dflt;

   assign ram_rd_addr0 = {col_ff, it_k_ff};
   assign ram_rd_addr1 = {SLOT_W'(col_ff + 1'b1), it_k_ff};

   always_comb begin
      state_in      = state_ff;
      sweep_ptr_in  = sweep_ptr_ff;
      epoch_in      = epoch_ff;
      fill_dc_in    = fill_dc_ff;
      mb_per_row_in = mb_per_row_ff;
      pixel_bits_in = pixel_bits_ff;
      cache_ok_in   = cache_ok_ff;
      cache_mb_in   = cache_mb_ff;
      col_in        = col_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      it_fill_in    = it_fill_ff;
      it_mb_in      = it_mb_ff;
      it_k_in       = it_k_ff;
      it_left_in    = it_left_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_a_in      = rsp_a_ff;
      rsp_b_in      = rsp_b_ff;
      rsp_c_in      = rsp_c_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = {col_ff, it_k_ff};
      ram_wr_data = '{tag: epoch_ff, coef: it_left_ff};
      ram_rd_en   = 1'b0;

      mod_req.start    = 1'b0;
      mod_req.dividend = req_mb_index;
      mod_req.divisor  = row_w;

      case (state_ff)
         ST_SWEEP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_ptr_ff;
            ram_wr_data = '0;
            if (sweep_ptr_ff == SWEEP_LAST) begin
               sweep_ptr_in = '0;
               state_in     = ST_IDLE;
            end else begin
               sweep_ptr_in = sweep_ptr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
         end
         ST_DIV: begin
            if (mod_stat.done) begin
               col_in      = mod_stat.rem;
               cache_mb_in = it_mb_ff;
               cache_ok_in = 1'b1;
               state_in    = ST_RD;
            end
         end
         ST_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = it_k_ff;
               if (it_fill_ff) begin
                  rsp_a_in   = fill_dflt;
                  rsp_b_in   = fill_dflt;
                  rsp_c_in   = fill_dflt;
                  fill_dc_in = default_dc(pixel_bits_ff);
                  if (wrap) begin
                     epoch_in = EPOCH_FIRST;
                     state_in = ST_SWEEP;
                  end else begin
                     epoch_in = epoch_ff + 1'b1;
                     state_in = ST_IDLE;
                  end
               end else begin
                  ram_wr_en = 1'b1;
                  if (col_ff == '0) begin
                     // last block of the previous row goes to slot row_w, just past the row
                     ram_wr_addr = {row_w, it_k_ff};
                     rsp_a_in    = fill_dflt;
                     rsp_b_in    = fill_dflt;
                  end else begin
                     rsp_a_in = it_left_ff;
                     rsp_b_in = b_val;
                  end
                  rsp_c_in = c_val;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (accept) begin
         it_fill_in = req_fill;
         it_mb_in   = req_mb_index;
         it_k_in    = req_coef_index;
         it_left_in = $unsigned(req_left_coef);
         if (req_fill) begin
            state_in = ST_EMIT;
         end else if (hit) begin
            state_in = ST_RD;
         end else begin
            mod_req.start = 1'b1;
            state_in      = ST_DIV;
         end
      end

      if (csr_wr_en) begin
         cache_ok_in = 1'b0;
         case (csr_index_type'(csr_index))
            CSR_MB_PER_ROW: mb_per_row_in = csr_wr_data[ROW_CFG_W-1:0];
            CSR_PIXEL_BITS: pixel_bits_in = csr_wr_data[PIX_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      it_fill_ff   <= it_fill_in;
      it_mb_ff     <= it_mb_in;
      it_k_ff      <= it_k_in;
      it_left_ff   <= it_left_in;
      cache_mb_ff  <= cache_mb_in;
      col_ff       <= col_in;
      rsp_index_ff <= rsp_index_in;
      rsp_a_ff     <= rsp_a_in;
      rsp_b_ff     <= rsp_b_in;
      rsp_c_ff     <= rsp_c_in;
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_ptr_ff  <= '0;
         epoch_ff      <= EPOCH_FIRST;
         fill_dc_ff    <= default_dc(PIXEL_BITS_RESET);
         mb_per_row_ff <= MB_PER_ROW_RESET;
         pixel_bits_ff <= PIXEL_BITS_RESET;
         cache_ok_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ptr_ff  <= sweep_ptr_in;
         epoch_ff      <= epoch_in;
         fill_dc_ff    <= fill_dc_in;
         mb_per_row_ff <= mb_per_row_in;
         pixel_bits_ff <= pixel_bits_in;
         cache_ok_ff   <= cache_ok_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_a_coef    = $signed(rsp_a_ff);
   assign rsp_b_coef    = $signed(rsp_b_ff);
   assign rsp_c_coef    = $signed(rsp_c_ff);

   // generation zero is reserved for cleared entries
   `IPNLS_ASSERT_IMPL(a_epoch_nonzero, 1'b1, epoch_ff != '0, "epoch tag reached zero")
   `IPNLS_ASSERT_NEXT(a_fill_same, emit_fire && it_fill_ff,
      (rsp_a_ff == rsp_b_ff) && (rsp_b_ff == rsp_c_ff), "fill result not uniform")
   `IPNLS_ASSERT_NEXT(a_sweep_end, (state_ff == ST_SWEEP) && (sweep_ptr_ff == SWEEP_LAST),
      state_ff == ST_IDLE, "clearing pass did not end")
   `IPNLS_ASSERT_NEXT(a_div_to_rd, (state_ff == ST_DIV) && mod_stat.done,
      state_ff == ST_RD, "column not used after modulo")

endmodule

`default_nettype wire

FILE: dv/ipnls_neighbor_checker.sv
`timescale 1ns / 100ps
// scoreboard for the neighbor line store: mirrors the row store and csr settings,
// predicts the a/b/c neighbors of each request transaction and checks each response
// depends on ipnls_pkg
module ipnls_neighbor_checker (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   input  wire logic                                   req_ready,
   input  wire logic [ipnls_pkg::MB_W-1:0]             req_mb_index,
   input  wire logic                                   req_resync,
   input  wire logic [ipnls_pkg::COEF_W-1:0]           req_coef_index,
   input  wire logic signed [ipnls_pkg::COEF_BITS-1:0] req_left_coef,
   input  wire logic                                   rsp_valid,
   input  wire logic                                   rsp_ready,
   input  wire logic [ipnls_pkg::COEF_W-1:0]           rsp_out_index,
   input  wire logic signed [ipnls_pkg::COEF_BITS-1:0] rsp_a_coef,
   input  wire logic signed [ipnls_pkg::COEF_BITS-1:0] rsp_b_coef,
   input  wire logic signed [ipnls_pkg::COEF_BITS-1:0] rsp_c_coef,
   input  wire logic                                   csr_wr_en,
   input  wire logic [ipnls_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [ipnls_pkg::CSR_DATA_W-1:0]       csr_wr_data,
   output int                                          error_count,
   output int                                          pending_count
);

   import ipnls_pkg::*;

   typedef struct packed {
      logic [COEF_W-1:0]    index;
      logic [COEF_BITS-1:0] a;
      logic [COEF_BITS-1:0] b;
      logic [COEF_BITS-1:0] c;
   } neighbor_set_type;

   logic [COEF_BITS-1:0] line_store [SLOT_COUNT][COEFS_PER_BLOCK];
   logic [ROW_CFG_W-1:0] row_cfg;
   logic [PIX_W-1:0]     pix_cfg;
   neighbor_set_type     expected_neighbors [$];
   int                   mismatches = 0;

   // dc gets 1 << (bits + 2) cut to 16 bits, ac is zero
   function automatic logic [COEF_BITS-1:0] blank_coef(input int unsigned k);
      logic [31:0] dc;
      dc = 32'd1 << (pix_cfg + 2);
      return (k == 0) ? dc[COEF_BITS-1:0] : '0;
   endfunction

   task automatic blank_store();
      for (int j = 0; j < SLOT_COUNT; j++)
         for (int k = 0; k < COEFS_PER_BLOCK; k++)
            line_store[j][k] = blank_coef(k);
   endtask

   function automatic int unsigned active_width();
      if (row_cfg == 0)
         return 1;
      if (row_cfg > MAX_MB_PER_ROW)
         return MAX_MB_PER_ROW;
      return row_cfg;
   endfunction

   task automatic predict_neighbors(input logic [MB_W-1:0] mb, input logic resync,
                                    input logic [COEF_W-1:0] k,
                                    input logic [COEF_BITS-1:0] left);
      neighbor_set_type n;
      int unsigned      w;
      int unsigned      col;
      w = active_width();
      col = mb % w;
      n.index = k;
      if (mb == 0 || resync) begin
         blank_store();
         n.a = blank_coef(k);
         n.b = n.a;
         n.c = n.a;
      end else if (col == 0) begin
         // left block closes the previous row, parked in slot w, just past the row
         n.a = blank_coef(k);
         n.b = n.a;
         n.c = line_store[1][k];
         line_store[w][k] = left;
      end else begin
         n.a = left;
         n.b = line_store[col][k];
         n.c = line_store[col + 1][k];
         line_store[col][k] = left;
      end
      expected_neighbors.push_back(n);
   endtask

   task automatic report_mismatch(input string what);
      $display("checker: %0t %s", $time, what);
      mismatches++;
   endtask

   task automatic compare_coef(input string field, input logic [COEF_BITS-1:0] want,
                               input logic [COEF_BITS-1:0] got);
      if (got !== want)
         report_mismatch($sformatf("%s exp %0d got %0d", field, $signed(want), $signed(got)));
   endtask

   task automatic check_response();
      neighbor_set_type want;
      if (expected_neighbors.size() == 0) begin
         report_mismatch("response with no transaction outstanding");
         return;
      end
      want = expected_neighbors.pop_front();
      if (rsp_out_index !== want.index)
         report_mismatch($sformatf("out_index exp %0d got %0d", want.index, rsp_out_index));
      compare_coef("a_coef", want.a, rsp_a_coef);
      compare_coef("b_coef", want.b, rsp_b_coef);
      compare_coef("c_coef", want.c, rsp_c_coef);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         row_cfg = MB_PER_ROW_RESET;
         pix_cfg = PIXEL_BITS_RESET;
         blank_store();
         expected_neighbors.delete();
      end else begin
         if (rsp_valid && rsp_ready)
            check_response();
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MB_PER_ROW: row_cfg = csr_wr_data[ROW_CFG_W-1:0];
               CSR_PIXEL_BITS: pix_cfg = csr_wr_data[PIX_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            predict_neighbors(req_mb_index, req_resync, req_coef_index, req_left_coef);
      end
      pending_count <= expected_neighbors.size();
      error_count <= mismatches;
   end

endmodule

FILE: dv/tb_intra_pred_neighbor_line_store.sv
`timescale 1ns / 100ps
// testbench top for the neighbor line store: clock, reset, csr settings and
// coefficient transactions under several idle/stall mixes, then the verdict
// depends on ipnls_pkg, intra_pred_neighbor_line_store and ipnls_neighbor_checker
module tb_intra_pred_neighbor_line_store;
   import ipnls_pkg::*;

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int SETTLE_CYCLES  = 24;
   localparam int PHASES         = 8;

   logic                        clock;
   logic                        reset          = 1'b1;
   logic                        req_valid      = 1'b0;
   logic                        req_ready;
   logic [MB_W-1:0]             req_mb_index   = '0;
   logic                        req_resync     = 1'b0;
   logic [COEF_W-1:0]           req_coef_index = '0;
   logic signed [COEF_BITS-1:0] req_left_coef  = '0;
   logic                        rsp_valid;
   logic                        rsp_ready      = 1'b0;
   logic [COEF_W-1:0]           rsp_out_index;
   logic signed [COEF_BITS-1:0] rsp_a_coef;
   logic signed [COEF_BITS-1:0] rsp_b_coef;
   logic signed [COEF_BITS-1:0] rsp_c_coef;
   logic                        csr_wr_en      = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index      = CSR_MB_PER_ROW;
   logic [CSR_DATA_W-1:0]       csr_wr_data    = '0;
   int                          error_count;
   int                          pending_count;

   int                   idle_pct     = 0;
   int                   stall_pct    = 0;
   int                   quiet_cycles = 0;
   int                   sent         = 0;
   logic [ROW_CFG_W-1:0] row_setting  = MB_PER_ROW_RESET;

   int unsigned phase_row [PHASES] = '{22, 1, 64, 0, 127, 2, 3, 9};
   int unsigned phase_pix [PHASES] = '{8, 4, 12, 15, 13, 0, 12, 4};

   intra_pred_neighbor_line_store dut (.*);
   ipnls_neighbor_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   function automatic logic [COEF_BITS-1:0] pick_coef();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7fff;
         default: return COEF_BITS'($urandom);
      endcase
   endfunction

   task automatic send_item(input logic [MB_W-1:0] mb, input logic rs,
                            input logic [COEF_W-1:0] k, input logic [COEF_BITS-1:0] left);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct)
            @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mb_index <= mb;
      req_resync <= rs;
      req_coef_index <= k;
      req_left_coef <= left;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      sent++;
   endtask

   task automatic send_noise();
      send_item(($urandom_range(7) == 0) ? '0 : MB_W'($urandom), $urandom_range(1) == 1,
                COEF_W'($urandom), pick_coef());
   endtask

   // settings change only once the block has drained and is ready again
   task automatic write_settings(input logic [ROW_CFG_W-1:0] row, input logic [PIX_W-1:0] pb);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MB_PER_ROW;
      csr_wr_data <= CSR_DATA_W'(row);
      @(posedge clock);
      csr_index <= CSR_PIXEL_BITS;
      csr_wr_data <= {3'($urandom_range(7)), pb};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      row_setting = row;
   endtask

   // raster pictures of a few rows, mostly from picture start, with stray
   // transactions and resyncs mixed in
   task automatic run_pictures(input int quota);
      int          goal;
      int unsigned w;
      int unsigned rows;
      int unsigned base;
      int unsigned last;
      logic        rs;
      int          keys [$];
      goal = sent + quota;
      w = (row_setting == 0) ? 1 :
          (row_setting > MAX_MB_PER_ROW) ? MAX_MB_PER_ROW : row_setting;
      while (sent < goal) begin
         rows = $urandom_range(2, 4);
         base = ($urandom_range(9) == 0) ? w * $urandom_range(1, 20) : 0;
         last = base + rows * w;
         if (last > 8192)
            last = 8192;
         keys.delete();
         if (w <= 8) begin
            for (int k = 0; k < COEFS_PER_BLOCK; k++)
               keys.push_back(k);
         end else begin
            // wide rows: keep a couple of coefficients so rows wrap quickly
            keys.push_back(0);
            keys.push_back($urandom_range(1, COEFS_PER_BLOCK - 1));
         end
         for (int unsigned m = base; m < last && sent < goal; m++) begin
            rs = (m != base) && ($urandom_range(19) == 0);
            foreach (keys[i]) begin
               if ($urandom_range(19) == 0)
                  send_noise();
               send_item(MB_W'(m), rs, COEF_W'(keys[i]), pick_coef());
            end
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset store contents, picture start, row wrap, resync and field extremes
      send_item(13'd5, 1'b0, 4'd0, 16'h7fff);
      send_item(13'd5, 1'b0, 4'd15, 16'h8000);
      send_item(13'd0, 1'b0, 4'd0, 16'h1234);
      send_item(13'd0, 1'b0, 4'd15, 16'hffff);
      send_item(13'd1, 1'b0, 4'd0, 16'h8000);
      send_item(13'd1, 1'b0, 4'd15, 16'h7fff);
      send_item(13'd21, 1'b0, 4'd0, 16'h0001);
      send_item(13'd22, 1'b0, 4'd0, 16'h0007);
      send_item(13'd23, 1'b0, 4'd0, 16'hffff);
      send_item(13'd44, 1'b0, 4'd15, 16'h0000);
      send_item(13'd30, 1'b1, 4'd3, 16'h5555);
      send_item(13'd8191, 1'b0, 4'd15, 16'haaaa);
      send_item(13'd8191, 1'b1, 4'd0, 16'h8000);
      send_item(13'd43, 1'b0, 4'd0, 16'h7fff);
      run_pictures(150);

      for (int p = 1; p < PHASES; p++) begin
         write_settings(ROW_CFG_W'(phase_row[p]), PIX_W'(phase_pix[p]));
         case (p % 4)
            1: begin idle_pct <= 63; stall_pct <= 0; end
            2: begin idle_pct <= 0; stall_pct <= 63; end
            3: begin idle_pct <= 17; stall_pct <= 17; end
            default: begin idle_pct <= 0; stall_pct <= 0; end
         endcase
         run_pictures(190);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

FILE: files.f
+incdir+design
design/ipnls_pkg.sv
design/ipnls_ram.sv
design/ipnls_mod_unit.sv
design/intra_pred_neighbor_line_store.sv
dv/ipnls_neighbor_checker.sv
dv/tb_intra_pred_neighbor_line_store.sv
